@@ rtl/core/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and constants shared by the fixed partition allocator modules.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // request kinds
    localparam logic REQ_ALLOCATE = 1'b0;
    localparam logic REQ_RELEASE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_NO_ROOM  = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // configuration register indexes
    localparam logic REG_PARTITION_SIZE    = 1'b0;
    localparam logic REG_ACTIVE_PARTITIONS = 1'b1;

    localparam logic [15:0] PARTITION_SIZE_RST    = 16'd256;
    localparam logic [6:0]  ACTIVE_PARTITIONS_RST = 7'd64;

    typedef struct packed {
        logic        req_type;
        logic [15:0] proc_id;
        logic [23:0] proc_size;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  part_index;
        logic [15:0] leftover;
        logic [6:0]  freed_count;
        logic        last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic fit_step;
        logic claim_start;
        logic claim_step;
        logic rel_step;
        logic emit_no_room;
        logic emit_empty;
        logic emit_released;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic at_end;
        logic cur_free;
        logic fit_cover;
        logic rel_done;
        logic is_release;
        logic size_zero;
    } sts_t;

endpackage

@@ rtl/core/fpa_ram.sv @@
// ----------------------------------------------------------------------------
// fpa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/fpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpa_ctrl
// Sequencer for the allocator: fit scan, claim scan and release scan.
// ----------------------------------------------------------------------------
module fpa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fpa_pkg::sts_t sts,
    output fpa_pkg::cmd_t cmd
);

    import fpa_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIT   = 2'd1;
    localparam logic [1:0] S_CLAIM = 2'd2;
    localparam logic [1:0] S_REL   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (sts.is_release)
                    begin
                        state_next = S_REL;
                    end
                    else if (sts.size_zero)
                    begin
                        cmd.emit_empty = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FIT;
                    end
                end
            end
            S_FIT:
            begin
                if (sts.at_end)
                begin
                    cmd.emit_no_room = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (sts.cur_free && sts.fit_cover)
                begin
                    cmd.claim_start = 1'b1;
                    state_next      = S_CLAIM;
                end
                else
                begin
                    cmd.fit_step = 1'b1;
                end
            end
            S_CLAIM:
            begin
                cmd.claim_step = 1'b1;
                // the fit scan guarantees the size is covered before the end
                if ((sts.cur_free && sts.fit_cover) || sts.at_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REL:
            begin
                cmd.rel_step = 1'b1;
                if (sts.rel_done)
                begin
                    cmd.emit_released = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_alloc_enters_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !sts.is_release && !sts.size_zero) |=> (state_reg == S_FIT))
        else $error("allocate did not start fit scan");

    a_claim_not_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAIM) |-> !sts.at_end)
        else $error("claim scan ran past the active partitions");

endmodule

@@ rtl/core/fpa_datapath.sv @@
// ----------------------------------------------------------------------------
// fpa_datapath
// Partition table, scan index, remaining size, owner RAM and result register.
// ----------------------------------------------------------------------------
module fpa_datapath #(
    parameter int MAX_PARTITIONS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fpa_pkg::request_t request,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    input  fpa_pkg::cmd_t    cmd,
    output fpa_pkg::sts_t    sts,
    output logic             valid,
    output fpa_pkg::result_t result
);

    import fpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTITIONS);
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    logic [15:0]               part_size_reg;
    logic [6:0]                active_reg;
    logic [MAX_PARTITIONS-1:0] in_use_reg;
    logic [MAX_PARTITIONS-1:0] in_use_next;
    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          idx_next;
    logic [23:0]               need_reg;
    logic [23:0]               need_next;
    logic [23:0]               size_reg;
    logic [15:0]               pid_reg;
    logic [CNT_W-1:0]          freed_reg;
    logic [CNT_W-1:0]          freed_next;
    logic                      rd_pend_reg;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic                      valid_reg;
    logic                      valid_next;
    result_t                   result_reg;
    result_t                   result_next;

    logic [CMP_W-1:0] active_ext;
    logic [CNT_W-1:0] span;
    logic [IDX_W-1:0] idx_lo;
    logic [15:0]      owner_rd;
    logic             claim_now;
    logic             rel_hit;
    logic             rd_issue;

    assign active_ext = CMP_W'(active_reg);
    assign span       = (active_ext > CMP_W'(MAX_PARTITIONS)) ? CNT_W'(MAX_PARTITIONS)
                                                              : CNT_W'(active_ext);
    assign idx_lo     = idx_reg[IDX_W-1:0];

    assign sts.at_end     = (idx_reg >= span);
    assign sts.cur_free   = !sts.at_end && !in_use_reg[idx_lo];
    assign sts.fit_cover  = ({8'd0, part_size_reg} >= need_reg);
    assign sts.rel_done   = sts.at_end && !rd_pend_reg;
    assign sts.is_release = (request.req_type == REQ_RELEASE);
    assign sts.size_zero  = (request.proc_size == 24'd0);

    assign claim_now = cmd.claim_step && sts.cur_free;
    assign rd_issue  = cmd.rel_step && !sts.at_end;
    assign rel_hit   = rd_pend_reg && in_use_reg[rd_idx_reg] && (owner_rd == pid_reg);

    fpa_ram #(
        .WIDTH (16),
        .DEPTH (MAX_PARTITIONS)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (claim_now),
        .wr_addr (idx_lo),
        .wr_data (pid_reg),
        .rd_en   (rd_issue),
        .rd_addr (idx_lo),
        .rd_data (owner_rd)
    );

    always_comb
    begin
        in_use_next = in_use_reg;
        idx_next    = idx_reg;
        need_next   = need_reg;
        freed_next  = freed_reg;
        valid_next  = 1'b0;
        result_next = '0;

        if (cmd.load)
        begin
            idx_next   = '0;
            need_next  = request.proc_size;
            freed_next = '0;
        end
        if (cmd.claim_start)
        begin
            idx_next  = '0;
            need_next = size_reg;
        end
        if (cmd.fit_step)
        begin
            idx_next = idx_reg + CNT_W'(1);
            if (sts.cur_free)
            begin
                need_next = need_reg - {8'd0, part_size_reg};
            end
        end
        if (cmd.claim_step && !sts.at_end)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (claim_now)
        begin
            in_use_next[idx_lo]    = 1'b1;
            valid_next             = 1'b1;
            result_next.status     = ST_GRANTED;
            result_next.part_index = 6'(idx_reg);
            if (sts.fit_cover)
            begin
                need_next            = '0;
                result_next.leftover = part_size_reg - need_reg[15:0];
                result_next.last     = 1'b1;
            end
            else
            begin
                need_next = need_reg - {8'd0, part_size_reg};
            end
        end
        if (rd_issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (rel_hit)
        begin
            in_use_next[rd_idx_reg] = 1'b0;
            freed_next              = freed_reg + CNT_W'(1);
        end
        if (cmd.emit_no_room)
        begin
            valid_next         = 1'b1;
            result_next.status = ST_NO_ROOM;
            result_next.last   = 1'b1;
        end
        if (cmd.emit_empty)
        begin
            valid_next         = 1'b1;
            result_next.status = ST_EMPTY;
            result_next.last   = 1'b1;
        end
        if (cmd.emit_released)
        begin
            valid_next              = 1'b1;
            result_next.status      = ST_RELEASED;
            result_next.freed_count = 7'(freed_reg);
            result_next.last        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_size_reg <= PARTITION_SIZE_RST;
            active_reg    <= ACTIVE_PARTITIONS_RST;
            in_use_reg    <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PARTITION_SIZE:    part_size_reg <= cfg_data;
                    REG_ACTIVE_PARTITIONS: active_reg    <= cfg_data[6:0];
                    default:               ;
                endcase
            end
            in_use_reg  <= in_use_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_issue;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg   <= need_next;
        freed_reg  <= freed_next;
        rd_idx_reg <= idx_lo;
        result_reg <= result_next;
        if (cmd.load)
        begin
            size_reg <= request.proc_size;
            pid_reg  <= request.proc_id;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

    a_only_grants_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_reg.last) |-> (result_reg.status == ST_GRANTED))
        else $error("non-grant beat without last");

    a_compare_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(cmd.rel_step))
        else $error("owner compare without a release read");

endmodule

@@ rtl/core/fixed_partition_allocator_top.sv @@
// ----------------------------------------------------------------------------
// fixed_partition_allocator_top
// First-fit allocator over a table of equal-size partitions.
//
//   channel   signals                          moves
//   request   start, busy, request             one request beat
//   result    valid, result                    one result beat per strobe
//   config    cfg_we, cfg_index, cfg_data      one register write
//
// Release reads the owner RAM once per active partition (registered read)
// and answers after the last compare. Allocate runs a fit scan up to the
// covering partition, then a claim scan over the same entries, one
// partition per cycle; a refused request ends after the fit scan. A
// zero-size request is answered from idle without a scan.
// Results appear in the cycle after their scan step; the receiver cannot stall.
// Reset frees every partition and loads the register defaults.
// ----------------------------------------------------------------------------
module fixed_partition_allocator_top #(
    parameter int MAX_PARTITIONS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fpa_pkg::request_t request,
    output logic              valid,
    output fpa_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data
);

    import fpa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    fpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    fpa_datapath #(
        .MAX_PARTITIONS (MAX_PARTITIONS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .valid     (valid),
        .result    (result)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit partition allocator. A short directed
// table covers the empty, full and shrunk tables, zero and oversized requests
// and the register extremes. Several random phases follow, each under its own
// register setting, with allocate/release traffic over a small pool of ids.
// A local model of the partition table predicts every result beat that the table does not give.
// ----------------------------------------------------------------------------
module tb_top;

    import fpa_pkg::*;

    localparam int N_PART     = 64;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 48;
    localparam int QUIET_FROM = 260;   // no sender gaps past this item
    localparam int LIMIT      = 400000;

    typedef struct packed {
        logic        is_cfg;
        logic [15:0] cfg_ps;
        logic [15:0] cfg_ap;
        request_t    req;
        logic        typed;
        result_t     res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        valid;
    result_t     result;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // partition table as the block should hold it
    logic        m_in_use [N_PART];
    logic [15:0] m_owner [N_PART];
    logic [15:0] m_part_size;
    logic [6:0]  m_active;

    result_t     due_results[$];
    int unsigned mismatches;
    int unsigned cyc_count;
    int unsigned items_sent;
    logic [15:0] id_pool [8];
    dir_row_t    dir_tab [27];

    fixed_partition_allocator_top #(
        .MAX_PARTITIONS(N_PART)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .valid(valid),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cyc_count < LIMIT)
        begin
            @(posedge clk);
            cyc_count++;
        end
        $display("[fixed_partition_allocator_top] ERROR");
        $finish;
    end

    function automatic void note_mismatch(string what, result_t want, result_t got);
        if (mismatches < 10)
            $display("mismatch %s: want st=%0d idx=%0d left=%h freed=%0d last=%0d, got st=%0d idx=%0d left=%h freed=%0d last=%0d",
                     what, want.status, want.part_index, want.leftover, want.freed_count,
                     want.last, got.status, got.part_index, got.leftover, got.freed_count,
                     got.last);
        mismatches++;
    endfunction

    // First-fit table update; pushes the result beats when keep is set.
    function automatic void apply_request(request_t r, bit keep);
        int unsigned span;
        int unsigned need;
        int unsigned freed;
        int unsigned left;
        result_t     res;
        span  = (m_active > N_PART) ? N_PART : m_active;
        res   = '0;
        freed = 0;
        if (r.req_type == REQ_RELEASE)
        begin
            for (int i = 0; i < span; i++)
                if (m_in_use[i] && m_owner[i] == r.proc_id)
                begin
                    m_in_use[i] = 1'b0;
                    freed++;
                end
            res.status      = ST_RELEASED;
            res.freed_count = 7'(freed);
            res.last        = 1'b1;
            if (keep)
                due_results.push_back(res);
        end
        else if (r.proc_size == 0)
        begin
            res.status = ST_EMPTY;
            res.last   = 1'b1;
            if (keep)
                due_results.push_back(res);
        end
        else
        begin
            need = r.proc_size;
            for (int i = 0; i < span && need > 0; i++)
                if (!m_in_use[i])
                    need = (m_part_size >= need) ? 0 : need - m_part_size;
            if (need > 0)
            begin
                res.status = ST_NO_ROOM;
                res.last   = 1'b1;
                if (keep)
                    due_results.push_back(res);
            end
            else
            begin
                need = r.proc_size;
                for (int i = 0; i < span && need > 0; i++)
                    if (!m_in_use[i])
                    begin
                        if (m_part_size <= need)
                        begin
                            left = 0;
                            need = need - m_part_size;
                        end
                        else
                        begin
                            left = m_part_size - need;
                            need = 0;
                        end
                        m_in_use[i]    = 1'b1;
                        m_owner[i]     = r.proc_id;
                        res.status     = ST_GRANTED;
                        res.part_index = 6'(i);
                        res.leftover   = 16'(left);
                        res.last       = (need == 0);
                        if (keep)
                            due_results.push_back(res);
                    end
            end
        end
    endfunction

    // result checker: the receiver cannot stall, every strobe is a beat
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && valid === 1'b1)
        begin
            if (due_results.size() == 0)
                note_mismatch("unexpected beat", '0, result);
            else
            begin
                want = due_results.pop_front();
                if (result.status !== want.status || result.part_index !== want.part_index
                    || result.leftover !== want.leftover
                    || result.freed_count !== want.freed_count
                    || result.last !== want.last)
                    note_mismatch("field", want, result);
            end
        end
    end

    function automatic dir_row_t cfg_row(logic [15:0] ps, logic [15:0] ap);
        dir_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.cfg_ps = ps;
        row.cfg_ap = ap;
        return row;
    endfunction

    function automatic dir_row_t req_row(logic kind, logic [15:0] id, logic [23:0] size);
        dir_row_t row;
        row                = '0;
        row.req.req_type   = kind;
        row.req.proc_id    = id;
        row.req.proc_size  = size;
        return row;
    endfunction

    // single-beat row whose answer is known without the model
    function automatic dir_row_t known(logic kind, logic [15:0] id, logic [23:0] size,
                                       logic [1:0] st, logic [6:0] freed);
        dir_row_t row;
        row                 = req_row(kind, id, size);
        row.typed           = 1'b1;
        row.res.status      = st;
        row.res.freed_count = freed;
        row.res.last        = 1'b1;
        return row;
    endfunction

    task automatic write_regs(logic [15:0] ps, logic [15:0] ap);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PARTITION_SIZE;
        cfg_data  <= ps;
        @(posedge clk);
        cfg_index <= REG_ACTIVE_PARTITIONS;
        cfg_data  <= ap;
        @(posedge clk);
        cfg_we      <= 1'b0;
        m_part_size  = ps;
        m_active     = ap[6:0];
    endtask

    // wait until the block has nothing left in flight
    task automatic settle();
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic issue(request_t r, logic typed, result_t res);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_request(r, !typed);
        if (typed)
            due_results.push_back(res);
        items_sent++;
        if (items_sent < QUIET_FROM && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    function automatic logic [23:0] fitting_size();
        int unsigned top;
        if (m_part_size == 0)
            return 24'($urandom_range(1, 1000));
        top = m_part_size * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0)
            return 24'(top);
        return 24'($urandom_range(1, top));
    endfunction

    function automatic request_t random_request();
        request_t    r;
        int unsigned sel;
        sel         = $urandom_range(0, 99);
        r.proc_id   = id_pool[$urandom_range(0, 7)];
        r.req_type  = REQ_ALLOCATE;
        r.proc_size = fitting_size();
        if (sel >= 50 && sel < 75)
            r.req_type = REQ_RELEASE;
        else if (sel < 82 && sel >= 75)
        begin
            r.proc_id   = 16'($urandom);
            r.proc_size = '0;
        end
        else if (sel < 90 && sel >= 82)
        begin
            r.proc_id   = 16'($urandom);
            r.proc_size = 24'($urandom);
        end
        else if (sel < 95 && sel >= 90)
        begin
            r.req_type = REQ_RELEASE;
            r.proc_id  = 16'($urandom);
        end
        else if (sel >= 95)
            r.proc_id = 16'($urandom);
        if (r.req_type == REQ_RELEASE)
            r.proc_size = 24'($urandom);
        return r;
    endfunction

    task automatic random_regs();
        logic [15:0] ps;
        logic [15:0] ap;
        case ($urandom_range(0, 5))
            0: ps = 16'd1;
            1: ps = 16'($urandom_range(2, 64));
            2: ps = 16'd256;
            3: ps = 16'hFFFF;
            4: ps = 16'($urandom_range(1, 65535));
            default: ps = 16'($urandom_range(100, 4000));
        endcase
        case ($urandom_range(0, 5))
            0: ap = 16'd64;
            1: ap = 16'($urandom_range(1, 8));
            2: ap = 16'($urandom_range(9, 63));
            3: ap = 16'($urandom_range(65, 127)) | (16'($urandom) & 16'hFF80);
            4: ap = 16'd64 | (16'($urandom) & 16'hFF80);
            default: ap = 16'd2;
        endcase
        write_regs(ps, ap);
    endtask

    initial
    begin
        result_t none;
        int unsigned w;
        none       = '0;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_PARTITION_SIZE;
        cfg_data   = '0;
        mismatches = 0;
        cyc_count  = 0;
        items_sent = 0;
        m_part_size = PARTITION_SIZE_RST;
        m_active    = ACTIVE_PARTITIONS_RST;
        foreach (m_in_use[i])
        begin
            m_in_use[i] = 1'b0;
            m_owner[i]  = '0;
        end
        foreach (id_pool[i])
            id_pool[i] = 16'($urandom);

        dir_tab = '{
            known(REQ_RELEASE, 16'h0000, 24'h000000, ST_RELEASED, 7'd0),
            known(REQ_ALLOCATE, 16'hFFFF, 24'h000000, ST_EMPTY, 7'd0),
            known(REQ_ALLOCATE, 16'h0001, 24'hFFFFFF, ST_NO_ROOM, 7'd0),
            req_row(REQ_ALLOCATE, 16'h0000, 24'd1),
            req_row(REQ_ALLOCATE, 16'hFFFF, 24'd256),
            req_row(REQ_ALLOCATE, 16'h1234, 24'd257),
            req_row(REQ_ALLOCATE, 16'hABCD, 24'd15360),      // fills the table exactly
            known(REQ_ALLOCATE, 16'h0002, 24'd1, ST_NO_ROOM, 7'd0),
            known(REQ_RELEASE, 16'hABCD, 24'hFFFFFF, ST_RELEASED, 7'd60),
            known(REQ_RELEASE, 16'hABCD, 24'h000000, ST_RELEASED, 7'd0),
            known(REQ_RELEASE, 16'hFFFF, 24'h000000, ST_RELEASED, 7'd1),
            cfg_row(16'hFFFF, 16'd127),                      // count saturates
            known(REQ_ALLOCATE, 16'h5555, 24'hFFFFFF, ST_NO_ROOM, 7'd0),
            req_row(REQ_ALLOCATE, 16'h5555, 24'd196606),
            req_row(REQ_ALLOCATE, 16'h5555, 24'd65536),
            cfg_row(16'h0000, 16'd1),                        // zero-size partitions
            known(REQ_ALLOCATE, 16'h0007, 24'd1, ST_NO_ROOM, 7'd0),
            known(REQ_RELEASE, 16'h0000, 24'h000000, ST_RELEASED, 7'd1),
            cfg_row(16'h0001, 16'd0),                        // no partitions active
            known(REQ_ALLOCATE, 16'h0003, 24'd1, ST_NO_ROOM, 7'd0),
            known(REQ_RELEASE, 16'h1234, 24'h000000, ST_RELEASED, 7'd0),
            cfg_row(16'h8000, 16'hFF40),                     // upper data bits ignored
            known(REQ_RELEASE, 16'h1234, 24'h000000, ST_RELEASED, 7'd2),
            req_row(REQ_RELEASE, 16'h5555, 24'h000000),
            known(REQ_ALLOCATE, 16'h00FF, 24'h800000, ST_NO_ROOM, 7'd0),
            req_row(REQ_ALLOCATE, 16'hFF00, 24'h1FFFFF),     // every partition granted
            known(REQ_RELEASE, 16'hFF00, 24'h000000, ST_RELEASED, 7'd64)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
        begin
            if (dir_tab[k].is_cfg)
            begin
                settle();
                write_regs(dir_tab[k].cfg_ps, dir_tab[k].cfg_ap);
            end
            else
                issue(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].res);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            random_regs();
            for (int n = 0; n < PHASE_LEN; n++)
                issue(random_request(), 1'b0, none);
        end

        start <= 1'b0;
        for (w = 0; w < 20000 && due_results.size() != 0; w++)
            @(posedge clk);
        repeat (2 * N_PART + 8) @(posedge clk);
        if (due_results.size() != 0)
            note_mismatch("missing beat", due_results[0], '0);

        if (mismatches == 0)
            $display("[fixed_partition_allocator_top] OK");
        else
            $display("[fixed_partition_allocator_top] ERROR");
        $finish;
    end

endmodule
